// ===== rtl/md5pm_pkg.sv =====
package md5pm_pkg;

  localparam int NumSteps = 64;

  typedef enum logic [1:0] {
    REG_TARGET  = 2'd0,
    REG_EXCLUDE = 2'd1,
    REG_WIN_LO  = 2'd2,
    REG_WIN_HI  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              vld;
    logic [31:0]       ip;
    logic              excl;
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       c;
    logic [31:0]       d;
    logic [15:0][31:0] w;
  } stage_t;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'((5 * i) + 1);
      2'd2: g = 4'((3 * i) + 5);
      default: g = 4'(7 * i);
    endcase
    return g;
  endfunction

  // decimal digits of one octet: hundreds, tens, ones
  function automatic logic [11:0] octet_digits(input logic [7:0] v);
    logic [3:0] h;
    logic [7:0] r;
    logic [3:0] t;
    h = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
    r = v - 8'(h * 100);
    // r / 10 for r below 100
    t = 4'((16'(r) * 16'd205) >> 11);
    return {h, t, 4'(r - 8'(t * 10))};
  endfunction

endpackage

// ===== rtl/ipv4_md5_prefix_matcher_unit.sv =====
// channel  direction  tdata/fields (low bit first)               tuser
// in       slave      ip_address[31:0]                           -
// out      master     ip_echo[31:0] hash_prefix[55:32]           is_match[0]
//                     (zero fill to 64 bits)                     is_excluded[1]
// cfg      slave      cfg_index[1:0] selects register, cfg_data  -
// one address per cycle unless out stalls; 66 register stages
// (text build, 64 md5 steps, finish)
// each md5 step is one pipeline register stage holding the working words
// reset clears the valid bits and the registers to their defaults
// a stall at out freezes the whole pipeline; nothing is dropped or repeated
module ipv4_md5_prefix_matcher_unit
  import md5pm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // ip_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // ip_echo, hash_prefix, zero fill
  output logic [1:0]  out_tuser,  // is_match, is_excluded
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [23:0] target_r;
  logic        excl_priv_r;
  logic [31:0] win_lo_r;
  logic [31:0] win_hi_r;

  logic        adv;
  stage_t      pipe_r [NumSteps + 1];
  stage_t      pipe_nxt [NumSteps + 1];
  logic        out_vld_r;
  logic [31:0] out_ip_r;
  logic [23:0] out_pfx_r;
  logic        out_excl_r;
  logic        out_match_r;

  assign cfg_ready = 1'b1;
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      excl_priv_r <= 1'b1;
      win_lo_r    <= 32'd16843009;
      win_hi_r    <= 32'd3758096384;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_TARGET:  target_r    <= cfg_data[23:0];
        REG_EXCLUDE: excl_priv_r <= cfg_data[0];
        REG_WIN_LO:  win_lo_r    <= cfg_data;
        REG_WIN_HI:  win_hi_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: exclusion test and message block
  always_comb begin
    logic [31:0] ip;
    logic        priv;
    logic [7:0]  blk [64];
    logic [11:0] dg;
    logic [5:0]  n;
    logic [7:0]  oct;
    ip = in_tdata;
    priv = (ip[31:24] == 8'd10) || (ip[31:24] == 8'd127) ||
           (ip[31:20] == 12'hac1) || (ip[31:16] == 16'hc0a8);
    for (int j = 0; j < 64; j++) blk[j] = 8'h00;
    n = '0;
    for (int o = 0; o < 4; o++) begin
      oct = ip[31 - 8 * o -: 8];
      dg = octet_digits(oct);
      if (oct >= 8'd100) begin
        blk[n] = {4'h3, dg[11:8]};
        n = n + 6'd1;
      end
      if (oct >= 8'd10) begin
        blk[n] = {4'h3, dg[7:4]};
        n = n + 6'd1;
      end
      blk[n] = {4'h3, dg[3:0]};
      n = n + 6'd1;
      if (o < 3) begin
        blk[n] = 8'h2e;
        n = n + 6'd1;
      end
    end
    blk[n] = 8'h80;
    blk[56] = {n[4:0], 3'b000};
    blk[57] = {7'd0, n[5]};
    pipe_nxt[0].vld  = in_tvalid;
    pipe_nxt[0].ip   = ip;
    pipe_nxt[0].excl = (ip < win_lo_r) || (ip > win_hi_r) || (excl_priv_r && priv);
    pipe_nxt[0].a    = 32'h67452301;
    pipe_nxt[0].b    = 32'hefcdab89;
    pipe_nxt[0].c    = 32'h98badcfe;
    pipe_nxt[0].d    = 32'h10325476;
    for (int j = 0; j < 16; j++)
      pipe_nxt[0].w[j] = {blk[4*j+3], blk[4*j+2], blk[4*j+1], blk[4*j]};
  end

  // one md5 step per stage
  for (genvar s = 0; s < NumSteps; s++) begin : g_step
    always_comb begin
      logic [31:0] f;
      logic [31:0] t;
      logic [63:0] dbl;
      stage_t      cur;
      cur = pipe_r[s];
      case (s / 16)
        0: f = (cur.b & cur.c) | (~cur.b & cur.d);
        1: f = (cur.d & cur.b) | (~cur.d & cur.c);
        2: f = cur.b ^ cur.c ^ cur.d;
        default: f = cur.c ^ (cur.b | ~cur.d);
      endcase
      t = cur.a + f + sine_k(6'(s)) + cur.w[msg_idx(6'(s))];
      dbl = {t, t} << rot_s(6'(s));
      pipe_nxt[s+1]   = cur;
      pipe_nxt[s+1].a = cur.d;
      pipe_nxt[s+1].d = cur.c;
      pipe_nxt[s+1].c = cur.b;
      pipe_nxt[s+1].b = cur.b + dbl[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NumSteps; s++) pipe_r[s].vld <= 1'b0;
    end else if (adv) begin
      for (int s = 0; s <= NumSteps; s++) pipe_r[s] <= pipe_nxt[s];
    end
  end

  // finish: add chaining value, pick digest bytes, compare
  logic [31:0] fin_a;
  logic [23:0] fin_pfx;
  assign fin_a   = pipe_r[NumSteps].a + 32'h67452301;
  assign fin_pfx = pipe_r[NumSteps].excl ? 24'd0 : {fin_a[7:0], fin_a[15:8], fin_a[23:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= pipe_r[NumSteps].vld;
    end
    if (adv) begin
      out_ip_r    <= pipe_r[NumSteps].ip;
      out_pfx_r   <= fin_pfx;
      out_excl_r  <= pipe_r[NumSteps].excl;
      out_match_r <= !pipe_r[NumSteps].excl && (fin_pfx == target_r);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {8'd0, out_pfx_r, out_ip_r};
  assign out_tuser  = {out_excl_r, out_match_r};

endmodule

// ===== bench/ipv4_md5_prefix_matcher_unit_tb.sv =====
`timescale 1ns / 100ps

module ipv4_md5_prefix_matcher_unit_tb;
  import md5pm_pkg::*;

  localparam int LATENCY   = 66;
  localparam int MAX_CYCLE = 400000;
  localparam int N_RANDOM  = 880;

  typedef struct {
    logic [31:0] ip;
    logic [23:0] prefix;
    logic        hit;
    logic        excl;
  } md5_result_t;

  typedef struct {
    logic [31:0] ip;
    logic        known;
    logic [23:0] prefix;
    logic        excl;
  } addr_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;   // ip_echo[31:0], hash_prefix[55:32], zero fill
  logic [1:0]  out_tuser;   // is_match[0], is_excluded[1]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  ipv4_md5_prefix_matcher_unit uut (.*);

  // local copy of the block's registers
  logic [23:0] target_q;
  logic        excl_priv_q;
  logic [31:0] win_lo_q;
  logic [31:0] win_hi_q;

  md5_result_t pending_q[$];
  int unsigned n_mismatch;
  int unsigned cycle_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;

  const logic [31:0] sine_tbl[64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  const int shift_tbl[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic bit in_private(input logic [31:0] ip);
    return (ip >= 32'd167772160 && ip < 32'd184549376) ||
           (ip >= 32'd2130706432 && ip < 32'd2147483648) ||
           (ip >= 32'd2886729728 && ip < 32'd2887778304) ||
           (ip >= 32'd3232235520 && ip < 32'd3232301056);
  endfunction

  function automatic logic [23:0] dotted_md5_prefix(input logic [31:0] ip);
    logic [7:0]  blk[64];
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, f, t, x;
    int          n, g, r, s;
    int unsigned v;
    n = 0;
    foreach (blk[i]) blk[i] = 8'h00;
    for (int k = 3; k >= 0; k--) begin
      v = (ip >> (8 * k)) & 8'hff;
      if (v >= 100) begin blk[n] = 8'(48 + v / 100); n++; end
      if (v >= 10) begin blk[n] = 8'(48 + (v / 10) % 10); n++; end
      blk[n] = 8'(48 + v % 10);
      n++;
      if (k != 0) begin blk[n] = 8'h2e; n++; end
    end
    blk[n] = 8'h80;
    blk[56] = 8'(n * 8);
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      s = shift_tbl[r * 4 + i % 4];
      x = a + f + sine_tbl[i] + w[g];
      t = d; d = c; c = b;
      b = b + ((x << s) | (x >> (32 - s)));
      a = t;
    end
    a = a + 32'h67452301;
    return {a[7:0], a[15:8], a[23:16]};
  endfunction

  function automatic md5_result_t predict_match(input logic [31:0] ip);
    md5_result_t res;
    res.ip = ip;
    res.excl = (ip < win_lo_q) || (ip > win_hi_q) || (excl_priv_q && in_private(ip));
    res.prefix = res.excl ? 24'h0 : dotted_md5_prefix(ip);
    res.hit = !res.excl && res.prefix == target_q;
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("[ipv4_md5_prefix_matcher_unit] ERROR");
      $finish;
    end
  end

  // receiver with random stall; hold_off forces a long backpressure stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    md5_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected transaction: %h %b", out_tdata, out_tuser);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_tdata[31:0] !== exp_r.ip || out_tdata[55:32] !== exp_r.prefix ||
            out_tdata[63:56] !== 8'h0 || out_tuser[0] !== exp_r.hit ||
            out_tuser[1] !== exp_r.excl) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch ip %h: exp prefix %h match %b excl %b, got %h %b",
                     exp_r.ip, exp_r.prefix, exp_r.hit, exp_r.excl, out_tdata, out_tuser);
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TARGET:  target_q    = val[23:0];
      REG_EXCLUDE: excl_priv_q = val[0];
      REG_WIN_LO:  win_lo_q    = val;
      REG_WIN_HI:  win_hi_q    = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // drives one address; the queue entry is pushed at the accepting edge
  task automatic send_addr(input logic [31:0] ip, input md5_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ip;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(res);
  endtask

  function automatic logic [31:0] random_addr;
    case ($urandom_range(5))
      0: return {8'd10, 24'($urandom)};
      1: return {8'd127, 24'($urandom)};
      2: return {12'hac1, 20'($urandom)};
      3: return {16'hc0a8, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  addr_row_t dir_rows[17] = '{
    '{32'h00000000, 1'b1, 24'h0, 1'b1},   // below default window
    '{32'hffffffff, 1'b1, 24'h0, 1'b1},   // above default window
    '{32'h0a000001, 1'b1, 24'h0, 1'b1},   // 10/8
    '{32'h7f000001, 1'b1, 24'h0, 1'b1},   // loopback
    '{32'hac100000, 1'b1, 24'h0, 1'b1},   // 172.16/12 low end
    '{32'hac1fffff, 1'b1, 24'h0, 1'b1},   // 172.16/12 high end
    '{32'hc0a80101, 1'b1, 24'h0, 1'b1},   // 192.168/16
    '{32'h01010101, 1'b0, 24'h0, 1'b0},   // window edges
    '{32'he0000000, 1'b0, 24'h0, 1'b0},
    '{32'h01010100, 1'b1, 24'h0, 1'b1},
    '{32'he0000001, 1'b1, 24'h0, 1'b1},
    '{32'h09ffffff, 1'b0, 24'h0, 1'b0},
    '{32'h0b000000, 1'b0, 24'h0, 1'b0},
    '{32'hac0fffff, 1'b0, 24'h0, 1'b0},
    '{32'hac200000, 1'b0, 24'h0, 1'b0},
    '{32'h08080808, 1'b0, 24'h0, 1'b0},
    '{32'hc8c8c8c8, 1'b0, 24'h0, 1'b0}    // three-digit octets
  };

  initial begin
    md5_result_t res;
    logic [31:0] ip;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TARGET;
    cfg_data = '0;
    n_mismatch = 0;
    cycle_cnt = 0;
    hold_off = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 50;
    target_q = '0;
    excl_priv_q = 1'b1;
    win_lo_q = 32'd16843009;
    win_hi_q = 32'd3758096384;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      res = predict_match(dir_rows[i].ip);
      if (dir_rows[i].known) begin
        res.excl = dir_rows[i].excl;
        res.prefix = dir_rows[i].prefix;
        res.hit = 1'b0;
      end
      send_addr(dir_rows[i].ip, res);
    end
    in_tvalid <= 1'b0;
    drain();

    // whole space, private ranges hashed; target one known hit
    write_reg(REG_EXCLUDE, 32'h0);
    write_reg(REG_WIN_LO, 32'h0);
    write_reg(REG_WIN_HI, 32'hffffffff);
    write_reg(REG_TARGET, {8'h0, dotted_md5_prefix(32'h00000102)});
    foreach (dir_rows[i]) send_addr(dir_rows[i].ip, predict_match(dir_rows[i].ip));
    send_addr(32'h00000102, predict_match(32'h00000102));
    in_tvalid <= 1'b0;
    drain();
    // empty window
    write_reg(REG_WIN_LO, 32'hffffffff);
    write_reg(REG_WIN_HI, 32'h0);
    write_reg(REG_TARGET, 32'hffffffff);
    for (int i = 0; i < 4; i++) begin
      ip = random_addr();
      send_addr(ip, predict_match(ip));
    end
    in_tvalid <= 1'b0;
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 8;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i % 110 == 0) begin
        in_tvalid <= 1'b0;
        drain();
        write_reg(REG_EXCLUDE, $urandom_range(1));
        write_reg(REG_WIN_LO, ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(32'h20000000));
        write_reg(REG_WIN_HI, ($urandom_range(3) == 0) ? 32'hffffffff
                                                          : $urandom_range(32'hffffffff, 32'hc0000000));
        write_reg(REG_TARGET, $urandom);
      end
      if (i == N_RANDOM / 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      ip = random_addr();
      res = predict_match(ip);
      // occasionally aim the target at the next address to cover a hit
      if ($urandom_range(15) == 0 && !res.excl) begin
        in_tvalid <= 1'b0;
        drain();
        write_reg(REG_TARGET, {8'h0, res.prefix});
        res.hit = 1'b1;
      end
      send_addr(ip, res);
    end
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (n_mismatch == 0 && pending_q.size() == 0) begin
      $display("[ipv4_md5_prefix_matcher_unit] OK");
    end else begin
      $display("[ipv4_md5_prefix_matcher_unit] ERROR");
    end
    $finish;
  end

endmodule
